### sv/rpol_pkg.sv
// ---------------------------------------------------------------------------
// Range partition owner lookup: shared package
// Sizes, operation codes, the control state encoding and the structures
// that pass between the controller and the row of boundary cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpol_pkg;

	// Table geometry: one cell per boundary, one boundary more than ranks.
	localparam int MAX_RANKS   = 16;
	localparam int NUM_ENTRIES = MAX_RANKS + 1;
	localparam int ROW_WIDTH   = 24;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int RANK_W      = 5;
	localparam int OWNER_W     = 4;
	localparam int QRANK_W     = 8;
	localparam int OUT_ROW_W   = 23;

	// Operation codes carried with every input item.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_COMMIT = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// Controller states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EVAL = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic                        clear;
		logic                        load;
		logic [IDX_W-1:0]            index;
		logic signed [ROW_WIDTH-1:0] value;
		logic signed [ROW_WIDTH-1:0] equation;
	} cell_cmd_t;

	// Per-cell compare results, registered inside the cell.
	typedef struct packed {
		logic order_ok;
		logic above_eq;
	} cell_flags_t;

endpackage

`default_nettype wire

### sv/rpol_cell.sv
// ---------------------------------------------------------------------------
// Range partition owner lookup: boundary cell
// Holds one boundary entry, hands it to the previous cell every cycle and
// registers the local ordering and equation compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpol_cell (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [rpol_pkg::IDX_W-1:0]            cell_index,
	input  wire rpol_pkg::cell_cmd_t                   cmd,
	input  wire logic signed [rpol_pkg::ROW_WIDTH-1:0] next_entry,
	output logic signed [rpol_pkg::ROW_WIDTH-1:0]      entry,
	output rpol_pkg::cell_flags_t                      flags
);

	logic signed [rpol_pkg::ROW_WIDTH-1:0] entry_q;
	rpol_pkg::cell_flags_t                 flags_s1;

	// Boundary storage: cleared as a whole, written when the index matches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (cmd.clear) begin
			entry_q <= '0;
		end else if (cmd.load && (cmd.index == cell_index)) begin
			entry_q <= cmd.value;
		end
	end

	// Local compares against the neighbor's entry and the asked equation.
	always_ff @(posedge clk) begin
		flags_s1.order_ok <= (entry_q >= 0) && (entry_q <= next_entry);
		flags_s1.above_eq <= entry_q > $signed(cmd.equation);
	end

	assign entry = entry_q;
	assign flags = flags_s1;

endmodule

`default_nettype wire

### sv/range_partition_owner_lookup_top.sv
// ---------------------------------------------------------------------------
// Range partition owner lookup: top level
// Keeps a table of block boundaries in a row of cells, validates it on
// commit and answers owner and row range queries.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream; s_tuser carries the operation (clear,
//   load boundary, commit, query) and s_tdata the operands. Every item
//   gives exactly one result transfer on the m_ stream.
//   The register num_ranks is written through cfg_wen / cfg_wdata; the
//   user must write it only while the block is idle (the block itself
//   does not enforce this); it is sampled when a commit runs.
//   One item is processed at a time. After its transfer the item is
//   broadcast and the cells register their compares, then the cell flags
//   are reduced into the output register. s_tready rises together with
//   the write of the result.
//   If the receiver stalls, the finished result waits in the output
//   register and the next item may already be accepted; its result then
//   waits in the reduce step until the output register frees.
//   Reset clears the boundary table, the valid flag, the latched rank
//   count and total, sets num_ranks to one and empties the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_partition_owner_lookup_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [4:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// boundary_index[4:0], boundary_value[28:5], equation[52:29],
	// query_rank[60:53], zero pad[63:61]
	input  wire logic [63:0] s_tdata,
	// op[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// partition_valid[0], owner_found[1], owner_rank[5:2], range_found[6],
	// row_begin[29:7], row_end[52:30], zero pad[55:53]
	output logic [55:0]      m_tdata
);

	localparam int NE = rpol_pkg::NUM_ENTRIES;
	localparam int RW = rpol_pkg::ROW_WIDTH;

	rpol_pkg::state_t state_q;

	logic [rpol_pkg::RANK_W-1:0]    num_ranks_q;
	logic [1:0]                     op_q;
	logic [rpol_pkg::IDX_W-1:0]     bidx_q;
	logic signed [RW-1:0]           bval_q;
	logic signed [RW-1:0]           eq_q;
	logic [rpol_pkg::QRANK_W-1:0]   qrank_q;

	logic                           table_valid_q;
	logic [rpol_pkg::RANK_W-1:0]    committed_q;
	logic signed [RW-1:0]           total_q;

	logic                           eq_ok_s1;
	logic                           range_ok_s1;
	logic [rpol_pkg::IDX_W-1:0]     blk_s1;

	logic                           out_valid_q;
	logic [55:0]                    out_data_q;

	rpol_pkg::cell_cmd_t            cmd;
	logic signed [RW-1:0]           entry [NE];
	rpol_pkg::cell_flags_t          flags [NE];

	logic                           accept;
	logic                           leave_done;
	logic                           commit_ok;
	logic signed [RW-1:0]           commit_total;
	logic [rpol_pkg::OWNER_W-1:0]   owner;
	logic                           res_valid;
	logic                           res_owner_found;
	logic [rpol_pkg::OWNER_W-1:0]   res_owner;
	logic                           res_range_found;
	logic [rpol_pkg::OUT_ROW_W-1:0] res_begin;
	logic [rpol_pkg::OUT_ROW_W-1:0] res_end;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == rpol_pkg::ST_IDLE);
	assign leave_done = (state_q == rpol_pkg::ST_DONE) && (!out_valid_q || m_tready);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ranks_q <= rpol_pkg::RANK_W'(1);
		end else if (cfg_wen) begin
			num_ranks_q <= cfg_wdata;
		end
	end

	// Item register, captured on the input transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			bidx_q  <= s_tdata[4:0];
			bval_q  <= s_tdata[28:5];
			eq_q    <= s_tdata[52:29];
			qrank_q <= s_tdata[60:53];
		end
	end

	// Sequencer: idle, broadcast to the cells, reduce into the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpol_pkg::ST_IDLE;
		end else begin
			case (state_q)
				rpol_pkg::ST_IDLE: begin
					if (accept) state_q <= rpol_pkg::ST_EVAL;
				end
				rpol_pkg::ST_EVAL: begin
					state_q <= rpol_pkg::ST_DONE;
				end
				rpol_pkg::ST_DONE: begin
					if (leave_done) state_q <= rpol_pkg::ST_IDLE;
				end
				default: begin
					state_q <= rpol_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Command broadcast; the table only changes during the broadcast cycle.
	always_comb begin
		cmd.clear    = (state_q == rpol_pkg::ST_EVAL) && (op_q == rpol_pkg::OP_CLEAR);
		cmd.load     = (state_q == rpol_pkg::ST_EVAL) && (op_q == rpol_pkg::OP_LOAD);
		cmd.index    = bidx_q;
		cmd.value    = bval_q;
		cmd.equation = eq_q;
	end

	// Row of boundary cells, each fed by its upper neighbor; the top cell is fed by its own entry.
	for (genvar k = 0; k < NE; k++) begin : g_cell
		logic signed [RW-1:0] next_entry;
		if (k == NE - 1) begin : g_last
			assign next_entry = entry[k];
		end else begin : g_inner
			assign next_entry = entry[k+1];
		end
		rpol_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_index (rpol_pkg::IDX_W'(k)),
			.cmd        (cmd),
			.next_entry (next_entry),
			.entry      (entry[k]),
			.flags      (flags[k])
		);
	end

	// Query preconditions, registered alongside the cell compares.
	always_ff @(posedge clk) begin
		eq_ok_s1    <= table_valid_q && (eq_q >= 0) && (eq_q < total_q);
		range_ok_s1 <= table_valid_q &&
			(qrank_q < {{(rpol_pkg::QRANK_W - rpol_pkg::RANK_W){1'b0}}, committed_q});
		if (qrank_q == '0) begin
			blk_s1 <= rpol_pkg::IDX_W'(committed_q - rpol_pkg::RANK_W'(1));
		end else begin
			blk_s1 <= rpol_pkg::IDX_W'(qrank_q[rpol_pkg::IDX_W-1:0] - rpol_pkg::IDX_W'(1));
		end
	end

	// Reduction of the cell flags: ordering check and owner priority pick.
	always_comb begin
		commit_ok = (num_ranks_q != '0) &&
			(num_ranks_q <= rpol_pkg::RANK_W'(rpol_pkg::MAX_RANKS));
		for (int k = 0; k < rpol_pkg::MAX_RANKS; k++) begin
			if ((rpol_pkg::RANK_W'(k) < num_ranks_q) && !flags[k].order_ok) commit_ok = 1'b0;
		end
		commit_total = commit_ok ? entry[num_ranks_q] : '0;
		owner = '0;
		for (int k = rpol_pkg::MAX_RANKS - 1; k >= 1; k--) begin
			if ((rpol_pkg::RANK_W'(k) < committed_q) && flags[k].above_eq) begin
				owner = rpol_pkg::OWNER_W'(k);
			end
		end
	end

	// Result fields for the item in the reduce step.
	always_comb begin
		res_valid       = table_valid_q;
		res_owner_found = 1'b0;
		res_owner       = '0;
		res_range_found = 1'b0;
		res_begin       = '0;
		res_end         = '0;
		case (op_q)
			rpol_pkg::OP_COMMIT: begin
				res_valid = commit_ok;
			end
			rpol_pkg::OP_QUERY: begin
				res_owner_found = eq_ok_s1;
				res_owner       = eq_ok_s1 ? owner : '0;
				res_range_found = range_ok_s1;
				if (range_ok_s1) begin
					res_begin = entry[blk_s1][rpol_pkg::OUT_ROW_W-1:0];
					res_end   = entry[rpol_pkg::IDX_W'(blk_s1 + 1'b1)][rpol_pkg::OUT_ROW_W-1:0];
				end
			end
			default: begin
				res_valid = table_valid_q;
			end
		endcase
	end

	// Partition state: dropped by clear, load and commit, set by a good commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_valid_q <= 1'b0;
			committed_q   <= '0;
			total_q       <= '0;
		end else if (state_q == rpol_pkg::ST_EVAL) begin
			if (op_q == rpol_pkg::OP_CLEAR || op_q == rpol_pkg::OP_COMMIT) begin
				table_valid_q <= 1'b0;
				committed_q   <= '0;
				total_q       <= '0;
			end else if (op_q == rpol_pkg::OP_LOAD) begin
				table_valid_q <= 1'b0;
			end
		end else if (leave_done && (op_q == rpol_pkg::OP_COMMIT) && commit_ok) begin
			table_valid_q <= 1'b1;
			committed_q   <= num_ranks_q;
			total_q       <= commit_total;
		end
	end

	// Output register: filled from the reduce step, emptied on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_done) begin
			out_data_q <= {3'b000, res_end, res_begin, res_range_found, res_owner,
				res_owner_found, res_valid};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

### sv/rpol_checker.sv
// ---------------------------------------------------------------------------
// Range partition owner lookup: port checker
// Watches the top level's ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpol_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [55:0] m_tdata
);

	// A stalled result keeps its valid and its data.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Items are worked one at a time: no transfer right after a transfer.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// A found owner or range only comes from a valid partition.
	a_found_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1] || m_tdata[6]) |-> m_tdata[0])
		else $error("found flag without valid partition");

	// Fields of a miss read as zero.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[6] |-> (m_tdata[52:7] == '0) && (m_tdata[1] || m_tdata[5:2] == '0))
		else $error("nonzero fields on a miss");

endmodule

bind range_partition_owner_lookup_top rpol_checker u_rpol_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### dv/testbench.sv
// ---------------------------------------------------------------------------
// Range partition owner lookup: testbench
// Streams clear, load, commit and query items into the block and checks
// each result transfer against a boundary-table predictor or a directed
// row's typed expectation. A short directed table comes first, then random
// phases of well-formed and broken partitions and noise; both streams stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	// Result fields, lowest bit last, so the struct lines up with m_tdata[52:0].
	typedef struct packed {
		logic [rpol_pkg::OUT_ROW_W-1:0] row_end;
		logic [rpol_pkg::OUT_ROW_W-1:0] row_begin;
		logic                           range_found;
		logic [rpol_pkg::OWNER_W-1:0]   owner_rank;
		logic                           owner_found;
		logic                           partition_valid;
	} outcome_t;

	// One row of the directed table; cfg is a rank count written beforehand.
	typedef struct {
		int         cfg;
		logic [1:0] op;
		int         idx;
		int         val;
		int         eq;
		int         qr;
		bit         typed;
		outcome_t   want;
	} step_t;

	localparam int       NO_CFG       = -1;
	localparam int       DIR_ROWS     = 26;
	localparam int       RANDOM_ITEMS = 1750;
	localparam outcome_t NONE         = '0;
	localparam outcome_t ONLY_VALID   = '{partition_valid: 1'b1, default: '0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wen;
	logic [4:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	// Predicted copy of the block state.
	logic signed [rpol_pkg::ROW_WIDTH-1:0] bnd_tab [rpol_pkg::NUM_ENTRIES];
	bit                                    part_valid;
	int                                    live_ranks;
	logic signed [rpol_pkg::ROW_WIDTH-1:0] live_total;
	int                                    ranks_reg;

	outcome_t pending_outcomes [$];
	int       errors      = 0;
	int       items_sent  = 0;
	int       commits_ok  = 0;
	int       owner_hits  = 0;
	bit       calm        = 1'b0;

	range_partition_owner_lookup_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	// Run limit, several times the slowest correct run.
	initial begin
		#(5_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	// Cycles a side waits before its next transfer; none in calm stretches.
	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	// Applies one item to the predicted state and returns its result.
	function automatic outcome_t partition_step(logic [1:0] op, logic [4:0] idx,
			logic signed [rpol_pkg::ROW_WIDTH-1:0] val,
			logic signed [rpol_pkg::ROW_WIDTH-1:0] eq,
			logic [rpol_pkg::QRANK_W-1:0] qr);
		outcome_t r;
		int       n;
		int       j;
		int       blk;
		bit       order_ok;
		r = '0;
		case (op)
			rpol_pkg::OP_CLEAR: begin
				for (j = 0; j < rpol_pkg::NUM_ENTRIES; j++)
					bnd_tab[j] = '0;
				part_valid = 1'b0;
				live_ranks = 0;
				live_total = '0;
			end
			rpol_pkg::OP_LOAD: begin
				part_valid = 1'b0;
				if (idx <= rpol_pkg::MAX_RANKS)
					bnd_tab[idx] = val;
			end
			rpol_pkg::OP_COMMIT: begin
				n = ranks_reg;
				part_valid = 1'b0;
				live_ranks = 0;
				live_total = '0;
				if (n >= 1 && n <= rpol_pkg::MAX_RANKS) begin
					order_ok = 1'b1;
					for (j = 0; j < n; j++)
						if (bnd_tab[j] < 0 || bnd_tab[j] > bnd_tab[j+1])
							order_ok = 1'b0;
					if (order_ok) begin
						live_ranks = n;
						live_total = bnd_tab[n];
						part_valid = 1'b1;
						commits_ok++;
					end
				end
			end
			default: begin
				n = live_ranks;
				if (part_valid && n >= 1 && n <= rpol_pkg::MAX_RANKS) begin
					// The first boundary above the equation names its block.
					if (eq >= 0 && eq < live_total) begin
						j = 1;
						while (j < n && bnd_tab[j] <= eq)
							j++;
						r.owner_found = 1'b1;
						r.owner_rank  = (j - 1 < n - 1) ? 4'(j) : 4'd0;
						owner_hits++;
					end
					// Rank 0 owns the last block, rank k the block k-1.
					if (int'(qr) < n) begin
						blk = (qr == 0) ? n - 1 : int'(qr) - 1;
						r.range_found = 1'b1;
						r.row_begin   = bnd_tab[blk][rpol_pkg::OUT_ROW_W-1:0];
						r.row_end     = bnd_tab[blk+1][rpol_pkg::OUT_ROW_W-1:0];
					end
				end
			end
		endcase
		r.partition_valid = part_valid;
		return r;
	endfunction

	// Prints one line for a field that differs and counts it.
	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, name, got, want);
			errors++;
		end
	endtask

	// Drives one item after a random gap and records its expected result.
	task automatic send_item(logic [1:0] op, logic [4:0] idx, logic [23:0] val,
			logic [23:0] eq, logic [7:0] qr, bit typed, outcome_t want);
		int       gap;
		outcome_t pred;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  <= op;
		s_tdata  <= {3'b000, qr, eq, val, idx};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pred = partition_step(op, idx, val, eq, qr);
		pending_outcomes.push_back(typed ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// Holds the sender until every result has come and the block is idle.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes the rank count register while the block is idle.
	task automatic write_ranks(int v);
		settle_idle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v[4:0];
		ranks_reg = v & 31;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Result side: random stall per transfer.
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Compare each result transfer with the oldest expectation.
	always @(posedge clk) begin : result_check
		outcome_t got;
		outcome_t want;
		got = m_tdata[52:0];
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				check_field("unexpected result", 32'd1, 32'd0);
			end else begin
				want = pending_outcomes.pop_front();
				check_field("partition_valid", 32'(got.partition_valid),
					32'(want.partition_valid));
				check_field("owner_found", 32'(got.owner_found), 32'(want.owner_found));
				check_field("owner_rank", 32'(got.owner_rank), 32'(want.owner_rank));
				check_field("range_found", 32'(got.range_found), 32'(want.range_found));
				check_field("row_begin", 32'(got.row_begin), 32'(want.row_begin));
				check_field("row_end", 32'(got.row_end), 32'(want.row_end));
			end
		end
	end

	initial begin : stimulus
		step_t      dir_tab [DIR_ROWS];
		int         ranks;
		int         n;
		int         kind;
		int         top;
		int         cnt;
		int         k;
		int         pick;
		int         vals [$];
		logic [23:0] bad;
		logic [23:0] eq_v;
		logic [7:0]  qr_v;

		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= rpol_pkg::OP_CLEAR;
		for (k = 0; k < rpol_pkg::NUM_ENTRIES; k++)
			bnd_tab[k] = '0;
		part_valid = 1'b0;
		live_ranks = 0;
		live_total = '0;
		ranks_reg  = 1;

		dir_tab = '{
			// Nothing committed after reset.
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 0, 0, 1, NONE},
			// One rank over an all-zero table passes.
			'{NO_CFG, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 1, ONLY_VALID},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 0, 0, 1,
				'{partition_valid: 1'b1, range_found: 1'b1, default: '0}},
			// Full size with only the top boundary at the row maximum.
			'{16, rpol_pkg::OP_LOAD, 16, 8388607, 0, 0, 1, NONE},
			'{NO_CFG, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 1, ONLY_VALID},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 8388606, 0, 1,
				'{partition_valid: 1'b1, owner_found: 1'b1, range_found: 1'b1,
				  row_end: 23'h7FFFFF, default: '0}},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, -8388608, 16, 1, ONLY_VALID},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 8388607, 255, 1, ONLY_VALID},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 0, 15, 0, NONE},
			// Load past the table end only drops the flag.
			'{NO_CFG, rpol_pkg::OP_LOAD, 31, -1, 0, 0, 1, NONE},
			'{NO_CFG, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 0, NONE},
			// Negative first boundary fails the commit.
			'{NO_CFG, rpol_pkg::OP_LOAD, 0, -8388608, 0, 0, 1, NONE},
			'{NO_CFG, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 1, NONE},
			'{NO_CFG, rpol_pkg::OP_CLEAR, 0, 0, 0, 0, 1, NONE},
			// Four ranks of ten rows each.
			'{4, rpol_pkg::OP_LOAD, 1, 10, 0, 0, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_LOAD, 2, 20, 0, 0, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_LOAD, 3, 30, 0, 0, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_LOAD, 4, 40, 0, 0, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 9, 1, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 39, 3, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_QUERY, 0, 0, 40, 4, 0, NONE},
			// A boundary above its successor fails the commit.
			'{NO_CFG, rpol_pkg::OP_LOAD, 2, 35, 0, 0, 0, NONE},
			'{NO_CFG, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 0, NONE},
			// Rank counts of zero and above MAX_RANKS both fail.
			'{0, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 1, NONE},
			'{17, rpol_pkg::OP_COMMIT, 0, 0, 0, 0, 1, NONE}
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg != NO_CFG)
				write_ranks(dir_tab[i].cfg);
			send_item(dir_tab[i].op, dir_tab[i].idx[4:0], dir_tab[i].val[23:0],
				dir_tab[i].eq[23:0], dir_tab[i].qr[7:0], dir_tab[i].typed,
				dir_tab[i].want);
		end

		// Random phases: mostly well-formed partitions followed by queries.
		while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0:       ranks = $urandom_range(0, 31);
					1:       ranks = rpol_pkg::MAX_RANKS;
					2:       ranks = 1;
					default: ranks = $urandom_range(1, rpol_pkg::MAX_RANKS);
				endcase
				write_ranks(ranks);
			end
			kind = $urandom_range(0, 9);
			if (kind == 9) begin
				// Noise: any operation with any field values.
				cnt = $urandom_range(5, 15);
				for (k = 0; k < cnt; k++)
					send_item(2'($urandom), 5'($urandom), 24'($urandom), 24'($urandom),
						8'($urandom), 1'b0, NONE);
			end else begin
				n = (ranks_reg >= 1 && ranks_reg <= rpol_pkg::MAX_RANKS) ? ranks_reg
					: $urandom_range(1, rpol_pkg::MAX_RANKS);
				top = ($urandom_range(0, 3) == 0) ? 8388607 : $urandom_range(n, 200);
				vals.delete();
				for (k = 0; k <= n; k++)
					vals.push_back($urandom_range(0, top));
				vals.sort();
				if ($urandom_range(0, 1))
					vals[0] = 0;
				for (k = 0; k <= n; k++)
					send_item(rpol_pkg::OP_LOAD, 5'(k), 24'(vals[k]), 24'($urandom),
						8'($urandom), 1'b0, NONE);
				// Broken partition: one entry negative or out of order.
				if (kind >= 7) begin
					k = $urandom_range(0, n);
					if (k < n)
						bad = $urandom_range(0, 1) ? (24'h800000 | 24'($urandom))
							: 24'(vals[k+1] + 1);
					else
						bad = 24'(vals[n-1] - 1);
					send_item(rpol_pkg::OP_LOAD, 5'(k), bad, 24'($urandom), 8'($urandom),
						1'b0, NONE);
				end
				send_item(rpol_pkg::OP_COMMIT, 5'($urandom), 24'($urandom), 24'($urandom),
					8'($urandom), 1'b0, NONE);
				cnt = $urandom_range(3, 12);
				for (k = 0; k < cnt; k++) begin
					pick = $urandom_range(0, 5);
					case (pick)
						0, 1:    eq_v = 24'(vals[$urandom_range(0, n)] + $urandom_range(0, 2) - 1);
						2:       eq_v = 24'($urandom_range(0, vals[n]));
						3:       eq_v = 24'($urandom);
						4:       eq_v = $urandom_range(0, 1) ? 24'hFFFFFF : 24'(vals[n]);
						default: eq_v = 24'($urandom_range(0, 63));
					endcase
					qr_v = ($urandom_range(0, 4) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, n));
					send_item(rpol_pkg::OP_QUERY, 5'($urandom), 24'($urandom), eq_v, qr_v,
						1'b0, NONE);
				end
			end
		end

		calm = 1'b0;
		settle_idle();
		$display("Summary: %0d items, %0d passing commits, %0d owner lookups found.",
			items_sent, commits_ok, owner_hits);
		$display("Summary: clears, loads, commits and queries ran under random stalls.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
